### hw/rtl/ttint_pkg.sv
package ttint_pkg;

    localparam int TIME_W   = 32;
    localparam int SAMPLE_W = 32;
    localparam int FRAC_W   = 16;

    // input opcodes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_INTERP = 2'd2;
    localparam logic [1:0] OP_EVENT  = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // one result beat before it enters the output register
    typedef struct packed {
        logic [3:0]          out_channel;
        logic [SAMPLE_W-1:0] sample_value;
        logic                event_found;
        logic [TIME_W-1:0]   event_time;
        logic [1:0]          status;
        logic                last;
    } result_t;

endpackage

### hw/rtl/time_table_interpolator_unit.sv
// time table interpolator
// s_ channel: one command beat per item, opcode in s_tuser (append row, write
// sample to the newest row, interpolate query, event search). m_ channel: result
// beats, m_tlast on the final beat of each item. apb port: reg 0 channels in use
// (addr 0x0), reg 1 discrete mask (addr 0x4); write only while the unit is idle.
// the unit works on one item at a time; s_tready is high only when idle.
// append: one sample-ram write per channel slot to zero the new row.
// interpolate: row walk, fraction divider (one bit per cycle), then per-channel
// results paced by the single sample-ram read port (two reads per channel);
// clamped queries skip walk and divider.
// event search: skips rows before the window start, then per row compares each
// discrete channel with the row before; continuous channels are not read.
// results sit in an output register; a stalled m_tready holds the unit on that beat.
// reset clears row count, walk and event positions, last query time and config
// (channels 1, mask 0); table memories are not cleared, a new row is zeroed on append.
module time_table_interpolator_unit #(
    parameter int MAX_ROWS     = 1024,
    parameter int MAX_CHANNELS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata: channel[3:0], sample[35:4], query_time[67:36], end_time[99:68]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,
    // s_tuser: opcode[1:0]
    input  logic [1:0]   s_tuser,
    // m_tdata: out_channel[3:0], sample_value[35:4], event_found[36],
    // event_time[68:37], status[70:69]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import ttint_pkg::*;

    localparam int RW   = $clog2(MAX_ROWS);
    localparam int RCW  = $clog2(MAX_ROWS + 1);
    localparam int CW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int STRIDE = 2 ** CW;
    localparam int SAW  = RW + CW;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DISP = 5'd1;
    localparam logic [4:0] S_CLR  = 5'd2;
    localparam logic [4:0] S_WK   = 5'd3;
    localparam logic [4:0] S_T1   = 5'd4;
    localparam logic [4:0] S_DIV  = 5'd5;
    localparam logic [4:0] S_CA   = 5'd6;
    localparam logic [4:0] S_CB   = 5'd7;
    localparam logic [4:0] S_CM   = 5'd8;
    localparam logic [4:0] S_CS   = 5'd9;
    localparam logic [4:0] S_EK   = 5'd10;
    localparam logic [4:0] S_ECA  = 5'd11;
    localparam logic [4:0] S_ECB  = 5'd12;
    localparam logic [4:0] S_ECC  = 5'd13;
    localparam logic [4:0] S_ETM  = 5'd14;
    localparam logic [4:0] S_EMIT = 5'd15;

    localparam logic REG_CHANS = 1'b0;
    localparam logic REG_MASK  = 1'b1;

    logic [4:0]          state_reg, state_next;
    logic [RCW-1:0]      rc_reg, rc_next;
    logic [RW-1:0]       walk_reg, walk_next;
    logic [RCW-1:0]      evt_reg, evt_next;
    logic [TIME_W-1:0]   lq_reg, lq_next;
    logic [4:0]          chans_cfg_reg, chans_cfg_next;
    logic [15:0]         mask_reg, mask_next;
    logic [TIME_W-1:0]   first_reg, first_next;
    logic [TIME_W-1:0]   lastt_reg, lastt_next;
    logic [1:0]          op_reg, op_next;
    logic [3:0]          ch_reg, ch_next;
    logic [SAMPLE_W-1:0] smp_reg, smp_next;
    logic [TIME_W-1:0]   qt_reg, qt_next;
    logic [TIME_W-1:0]   et_reg, et_next;
    logic [RW-1:0]       w_reg, w_next;
    logic [CW-1:0]       c_reg, c_next;
    logic [RW-1:0]       r1_reg, r1_next;
    logic [RW-1:0]       r2_reg, r2_next;
    logic                use_r2_reg, use_r2_next;
    logic [FRAC_W:0]     frac_reg, frac_next;
    logic [TIME_W-1:0]   t2_reg, t2_next;
    logic [SAMPLE_W-1:0] va_reg, va_next;
    logic [SAMPLE_W-1:0] vb_reg, vb_next;
    logic signed [50:0]  prod_reg, prod_next;
    logic [TIME_W-1:0]   etime_reg, etime_next;
    result_t             res_reg, res_next;
    result_t             out_reg, out_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // memory ports
    logic                t_we;
    logic [RW-1:0]       t_waddr, t_raddr;
    logic [TIME_W-1:0]   t_wdata, t_rdata;
    logic                s_we;
    logic [SAW-1:0]      s_waddr, s_raddr;
    logic [SAMPLE_W-1:0] s_wdata, s_rdata;

    // divider
    logic                div_start, div_busy;
    logic [TIME_W-1:0]   div_num, div_den;
    logic [FRAC_W-1:0]   div_quot;

    logic                out_free;
    logic                cfg_wr;
    int                  chans_n;
    logic                c_last;
    logic                c_disc;

    ttint_ram #(.WIDTH(TIME_W), .DEPTH(MAX_ROWS)) u_time_ram (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    ttint_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ROWS * STRIDE)) u_sample_ram (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    ttint_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    // channel count and per-channel flags
    always_comb begin
        if (chans_cfg_reg == 5'd0) begin
            chans_n = 1;
        end else if (int'(chans_cfg_reg) > MAX_CHANNELS) begin
            chans_n = MAX_CHANNELS;
        end else begin
            chans_n = int'(chans_cfg_reg);
        end
        c_last = (int'(c_reg) + 1 == chans_n);
        c_disc = (int'(c_reg) < 16) && mask_reg[4'(c_reg)];
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign cfg_wr   = psel && penable && pwrite;

    // sequencer
    always_comb begin
        logic [TIME_W-1:0] tapp;
        logic [RW-1:0]     wstart;
        logic [RW-1:0]     rc_m1;
        logic signed [32:0] diff;
        state_next     = state_reg;
        rc_next        = rc_reg;
        walk_next      = walk_reg;
        evt_next       = evt_reg;
        lq_next        = lq_reg;
        chans_cfg_next = chans_cfg_reg;
        mask_next      = mask_reg;
        first_next     = first_reg;
        lastt_next     = lastt_reg;
        op_next        = op_reg;
        ch_next        = ch_reg;
        smp_next       = smp_reg;
        qt_next        = qt_reg;
        et_next        = et_reg;
        w_next         = w_reg;
        c_next         = c_reg;
        r1_next        = r1_reg;
        r2_next        = r2_reg;
        use_r2_next    = use_r2_reg;
        frac_next      = frac_reg;
        t2_next        = t2_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        prod_next      = prod_reg;
        etime_next     = etime_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        m_tvalid_next  = m_tvalid_reg;
        t_we           = 1'b0;
        t_waddr        = rc_reg[RW-1:0];
        t_wdata        = '0;
        t_raddr        = w_reg;
        s_we           = 1'b0;
        s_waddr        = {rc_reg[RW-1:0], c_reg};
        s_wdata        = '0;
        s_raddr        = {r1_reg, c_reg};
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = '0;
        rc_m1          = RW'(rc_reg - 1'b1);
        tapp           = qt_reg;
        wstart         = '0;
        diff           = '0;

        // output register drains independently
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // configuration writes
        if (cfg_wr) begin
            if (paddr[2] == REG_CHANS) begin
                chans_cfg_next = pwdata[4:0];
            end else begin
                mask_next = pwdata[15:0];
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    ch_next    = s_tdata[3:0];
                    smp_next   = s_tdata[35:4];
                    qt_next    = s_tdata[67:36];
                    et_next    = s_tdata[99:68];
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                res_next = '{out_channel: 4'd0, sample_value: '0, event_found: 1'b0,
                             event_time: '0, status: STAT_OK, last: 1'b1};
                unique case (op_reg)
                    OP_APPEND: begin
                        if (int'(rc_reg) >= MAX_ROWS) begin
                            res_next.status = STAT_FULL;
                            state_next      = S_EMIT;
                        end else begin
                            if (rc_reg != '0 && qt_reg < lastt_reg) begin
                                tapp = lastt_reg;
                            end
                            t_we       = 1'b1;
                            t_wdata    = tapp;
                            lastt_next = tapp;
                            if (rc_reg == '0) begin
                                first_next = tapp;
                            end
                            c_next     = '0;
                            state_next = S_CLR;
                        end
                    end
                    OP_WRITE: begin
                        res_next.out_channel = ch_reg;
                        if (rc_reg == '0) begin
                            res_next.status = STAT_EMPTY;
                        end else if (int'(ch_reg) < MAX_CHANNELS) begin
                            s_we    = 1'b1;
                            s_waddr = {rc_m1, CW'(ch_reg)};
                            s_wdata = smp_reg;
                        end
                        state_next = S_EMIT;
                    end
                    OP_INTERP: begin
                        if (rc_reg == '0) begin
                            res_next.status = STAT_EMPTY;
                            state_next      = S_EMIT;
                        end else begin
                            wstart  = (qt_reg < lq_reg) ? '0 : walk_reg;
                            lq_next = qt_reg;
                            c_next  = '0;
                            if (qt_reg <= first_reg) begin
                                walk_next   = '0;
                                r1_next     = '0;
                                r2_next     = '0;
                                use_r2_next = 1'b0;
                                frac_next   = '0;
                                state_next  = S_CA;
                            end else if (qt_reg >= lastt_reg) begin
                                walk_next   = rc_m1;
                                r1_next     = rc_m1;
                                r2_next     = rc_m1;
                                use_r2_next = 1'b0;
                                frac_next   = {1'b1, {FRAC_W{1'b0}}};
                                state_next  = S_CA;
                            end else begin
                                if (RCW'(wstart) + RCW'(1) > rc_reg) begin
                                    wstart = rc_m1;
                                end
                                w_next     = wstart;
                                t_raddr    = wstart;
                                state_next = S_WK;
                            end
                        end
                    end
                    default: begin
                        if (rc_reg < RCW'(2) || et_reg <= first_reg || qt_reg >= lastt_reg) begin
                            if (rc_reg == '0) begin
                                res_next.status = STAT_EMPTY;
                            end
                            state_next = S_EMIT;
                        end else begin
                            if (evt_reg == '0) begin
                                wstart = RW'(1);
                            end else if (evt_reg + RCW'(1) > rc_reg) begin
                                wstart = rc_m1;
                            end else begin
                                wstart = RW'(evt_reg);
                            end
                            w_next     = wstart;
                            t_raddr    = wstart;
                            state_next = S_EK;
                        end
                    end
                endcase
            end
            // zero the new row, one channel slot per cycle
            S_CLR: begin
                s_we    = 1'b1;
                s_waddr = {rc_reg[RW-1:0], c_reg};
                s_wdata = '0;
                if (int'(c_reg) == STRIDE - 1) begin
                    rc_next    = rc_reg + 1'b1;
                    state_next = S_EMIT;
                end else begin
                    c_next = c_reg + 1'b1;
                end
            end
            // forward walk: t_rdata holds the time of row w
            S_WK: begin
                if (RCW'(w_reg) + RCW'(1) < rc_reg && t_rdata < qt_reg) begin
                    w_next  = w_reg + 1'b1;
                    t_raddr = w_reg + 1'b1;
                end else begin
                    walk_next  = w_reg;
                    r2_next    = w_reg;
                    r1_next    = w_reg - 1'b1;
                    t2_next    = t_rdata;
                    t_raddr    = w_reg - 1'b1;
                    state_next = S_T1;
                end
            end
            S_T1: begin
                use_r2_next = (t2_reg == qt_reg);
                if (t2_reg == qt_reg || t2_reg <= t_rdata || qt_reg <= t_rdata) begin
                    frac_next  = {1'b1, {FRAC_W{1'b0}}};
                    state_next = S_CA;
                end else begin
                    div_start  = 1'b1;
                    div_num    = qt_reg - t_rdata;
                    div_den    = t2_reg - t_rdata;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (!div_busy) begin
                    frac_next  = {1'b0, div_quot};
                    state_next = S_CA;
                end
            end
            // per-channel reads: left row then right row
            S_CA: begin
                s_raddr    = {r1_reg, c_reg};
                state_next = S_CB;
            end
            S_CB: begin
                va_next    = s_rdata;
                s_raddr    = {r2_reg, c_reg};
                state_next = S_CM;
            end
            S_CM: begin
                vb_next    = s_rdata;
                diff       = $signed({s_rdata[31], s_rdata}) - $signed({va_reg[31], va_reg});
                prod_next  = 51'(diff * $signed({1'b0, frac_reg}));
                state_next = S_CS;
            end
            S_CS: begin
                res_next.out_channel = 4'(c_reg);
                res_next.event_found = 1'b0;
                res_next.event_time  = '0;
                res_next.status      = STAT_OK;
                res_next.last        = c_last;
                if (c_disc) begin
                    res_next.sample_value = use_r2_reg ? vb_reg : va_reg;
                end else begin
                    res_next.sample_value = va_reg + prod_reg[47:16];
                end
                state_next = S_EMIT;
            end
            // event search: skip rows before the window start
            S_EK: begin
                if (RCW'(w_reg) + RCW'(1) < rc_reg && t_rdata < qt_reg) begin
                    w_next  = w_reg + 1'b1;
                    t_raddr = w_reg + 1'b1;
                end else if (t_rdata <= et_reg) begin
                    etime_next = t_rdata;
                    c_next     = '0;
                    state_next = S_ECA;
                end else begin
                    evt_next   = RCW'(w_reg) - RCW'(1);
                    state_next = S_EMIT;
                end
            end
            S_ECA, S_ECC: begin
                if (state_reg == S_ECA && c_disc) begin
                    s_raddr    = {w_reg - 1'b1, c_reg};
                    state_next = S_ECB;
                end else if (state_reg == S_ECC && s_rdata != va_reg) begin
                    evt_next             = RCW'(w_reg) + RCW'(1);
                    res_next.out_channel = 4'(c_reg);
                    res_next.event_found = 1'b1;
                    res_next.event_time  = etime_reg;
                    state_next           = S_EMIT;
                end else if (!c_last) begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_ECA;
                end else if (RCW'(w_reg) + RCW'(1) >= rc_reg) begin
                    evt_next   = RCW'(w_reg);
                    state_next = S_EMIT;
                end else begin
                    w_next     = w_reg + 1'b1;
                    t_raddr    = w_reg + 1'b1;
                    state_next = S_ETM;
                end
            end
            S_ECB: begin
                va_next    = s_rdata;
                s_raddr    = {w_reg, c_reg};
                state_next = S_ECC;
            end
            S_ETM: begin
                if (t_rdata <= et_reg) begin
                    etime_next = t_rdata;
                    c_next     = '0;
                    state_next = S_ECA;
                end else begin
                    evt_next   = RCW'(w_reg) - RCW'(1);
                    state_next = S_EMIT;
                end
            end
            // hand one result beat to the output register
            S_EMIT: begin
                if (out_free) begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    if (res_reg.last) begin
                        state_next = S_IDLE;
                    end else begin
                        c_next     = c_reg + 1'b1;
                        state_next = S_CA;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            rc_reg        <= '0;
            walk_reg      <= '0;
            evt_reg       <= '0;
            lq_reg        <= '0;
            chans_cfg_reg <= 5'd1;
            mask_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rc_reg        <= rc_next;
            walk_reg      <= walk_next;
            evt_reg       <= evt_next;
            lq_reg        <= lq_next;
            chans_cfg_reg <= chans_cfg_next;
            mask_reg      <= mask_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        first_reg  <= first_next;
        lastt_reg  <= lastt_next;
        op_reg     <= op_next;
        ch_reg     <= ch_next;
        smp_reg    <= smp_next;
        qt_reg     <= qt_next;
        et_reg     <= et_next;
        w_reg      <= w_next;
        c_reg      <= c_next;
        r1_reg     <= r1_next;
        r2_reg     <= r2_next;
        use_r2_reg <= use_r2_next;
        frac_reg   <= frac_next;
        t2_reg     <= t2_next;
        va_reg     <= va_next;
        vb_reg     <= vb_next;
        prod_reg   <= prod_next;
        etime_reg  <= etime_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    // ports
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {1'b0, out_reg.status, out_reg.event_time, out_reg.event_found,
                       out_reg.sample_value, out_reg.out_channel};
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_MASK) ? {16'd0, mask_reg} : {27'd0, chans_cfg_reg};

endmodule

### hw/rtl/ttint_ram.sv
module ttint_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/ttint_div.sv
module ttint_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [ttint_pkg::TIME_W-1:0] num,
    input  logic [ttint_pkg::TIME_W-1:0] den,
    output logic                      busy,
    output logic [ttint_pkg::FRAC_W-1:0] quot
);
    import ttint_pkg::*;

    localparam int CNT_W = $clog2(FRAC_W);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W:0]   rem_reg, rem_next;
    logic [TIME_W-1:0] den_reg, den_next;
    logic [FRAC_W-1:0] quot_reg, quot_next;

    // restoring division, one quotient bit per cycle; num < den on entry
    always_comb begin
        logic [TIME_W:0] sh;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        sh        = {rem_reg[TIME_W-1:0], 1'b0};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = {1'b0, num};
            den_next  = den;
            quot_next = '0;
        end else if (busy_reg) begin
            if (sh >= {1'b0, den_reg}) begin
                rem_next  = sh - {1'b0, den_reg};
                quot_next = {quot_reg[FRAC_W-2:0], 1'b1};
            end else begin
                rem_next  = sh;
                quot_next = {quot_reg[FRAC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(FRAC_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule
